// ----- hw/rtl/gbdmb_pkg.sv -----
// Shared types, constants and helper functions of the glyph box downsampler.
// No dependencies; every other file of the block but gbdmb_ram imports this package.
`default_nettype none

package gbdmb_pkg;

    // Sizing of the block.
    localparam int MAX_GLYPH_SIDE     = 256;
    localparam int MAX_SURFACE_WIDTH  = 512;
    localparam int MAX_SURFACE_HEIGHT = 512;
    localparam int OVERSAMPLE         = 2;

    localparam int HALF_SIDE   = (MAX_GLYPH_SIDE + 1) / OVERSAMPLE;
    localparam int STORE_DEPTH = MAX_SURFACE_WIDTH * MAX_SURFACE_HEIGHT;

    // Field and datapath widths.
    localparam int COV_W    = 8;
    localparam int POS_W    = $clog2(MAX_GLYPH_SIDE);
    localparam int BLK_W    = $clog2(HALF_SIDE);
    localparam int PAIR_W   = COV_W + 1;
    localparam int SUM_W    = COV_W + 2;
    localparam int GSIZE_W  = 9;
    localparam int DEST_W   = 11;
    localparam int SSIZE_W  = 10;
    localparam int COORD_W  = 12;
    localparam int PX_W     = $clog2(MAX_SURFACE_WIDTH);
    localparam int PY_W     = $clog2(MAX_SURFACE_HEIGHT);
    localparam int STORE_AW = PX_W + PY_W;
    localparam int STRIDE_W = 11;
    localparam int OFFSET_W = 20;

    // Queue between the sample front end and the pixel back end (power of two).
    localparam int QUEUE_DEPTH = 4;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GLYPH_WIDTH    = 3'd0,
        REG_GLYPH_HEIGHT   = 3'd1,
        REG_DEST_X         = 3'd2,
        REG_DEST_Y         = 3'd3,
        REG_SURFACE_WIDTH  = 3'd4,
        REG_SURFACE_HEIGHT = 3'd5
    } cfg_reg_t;

    // Glyph geometry seen by the front end: index of the last column and row.
    typedef struct packed {
        logic [POS_W-1:0] last_col;
        logic [POS_W-1:0] last_row;
    } front_cfg_t;

    // Placement and clipping geometry seen by the back end.
    typedef struct packed {
        logic [DEST_W-1:0]   dest_x;
        logic [DEST_W-1:0]   dest_y;
        logic [SSIZE_W-1:0]  surf_w;
        logic [SSIZE_W-1:0]  surf_h;
        logic [STRIDE_W-1:0] stride;
    } back_cfg_t;

    // One finished 2x2 block on its way to the back end.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             col_odd;
        logic             row_odd;
        logic [BLK_W-1:0] bc;
        logic [BLK_W-1:0] br;
        logic             last;
    } blk_t;

    // Index of the last sample along one glyph side; zero counts as one and
    // sizes above the maximum saturate.
    function automatic logic [POS_W-1:0] side_last(input logic [GSIZE_W-1:0] size);
        logic [GSIZE_W-1:0] m1;
        m1 = size - GSIZE_W'(1);
        if (size == '0) begin
            return '0;
        end else if (size > GSIZE_W'(MAX_GLYPH_SIDE)) begin
            return POS_W'(MAX_GLYPH_SIDE - 1);
        end
        return m1[POS_W-1:0];
    endfunction

    function automatic logic [SSIZE_W-1:0] surf_clamp(input logic [SSIZE_W-1:0] size,
                                                      input logic [SSIZE_W-1:0] hi);
        if (size == '0) begin
            return SSIZE_W'(1);
        end else if (size > hi) begin
            return hi;
        end
        return size;
    endfunction

    // Row stride in bytes: three bytes a pixel, padded to a multiple of four.
    function automatic logic [STRIDE_W-1:0] row_stride(input logic [SSIZE_W-1:0] width);
        logic [STRIDE_W-1:0] padded;
        padded = STRIDE_W'(width) + {width, 1'b0} + STRIDE_W'(3);
        return {padded[STRIDE_W-1:2], 2'b00};
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gbdmb_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// No package dependencies.
`default_nettype none

module gbdmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/gbdmb_fifo.sv -----
// Short block queue between the sample front end and the pixel back end.
// Depends on gbdmb_pkg for blk_t and QUEUE_DEPTH.
`default_nettype none

module gbdmb_fifo
    import gbdmb_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire blk_t push_data,
    output logic      full,
    input  wire logic pop,
    output blk_t      pop_data,
    output logic      empty
);

    localparam int QA_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    blk_t             slot_reg [QUEUE_DEPTH];
    logic [QA_W-1:0]  wr_ptr_reg;
    logic [QA_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb begin
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QA_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QA_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("block queue written while full");
    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("block queue read while empty");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/gbdmb_front.sv -----
// Sample front end: tracks the glyph position, pairs samples, keeps the
// even-row pair sums in a line buffer and emits finished 2x2 blocks.
// Depends on gbdmb_pkg and gbdmb_ram.
`default_nettype none

module gbdmb_front
    import gbdmb_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_enable,
    input  wire front_cfg_t       geom,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [COV_W-1:0] s_coverage,
    output logic                  blk_push,
    output blk_t                  blk_data,
    input  wire logic             blk_full
);

    logic [POS_W-1:0]     col_reg;
    logic [POS_W-1:0]     col_next;
    logic [POS_W-1:0]     row_reg;
    logic [POS_W-1:0]     row_next;
    logic [COV_W-1:0]     pair_acc_reg;
    logic [HALF_SIDE-1:0] seen_reg;

    logic                 s1_valid_reg;
    logic [PAIR_W-1:0]    s1_pair_reg;
    logic                 s1_col_odd_reg;
    logic                 s1_row_odd_reg;
    logic [BLK_W-1:0]     s1_bc_reg;
    logic [BLK_W-1:0]     s1_br_reg;
    logic                 s1_last_reg;
    logic                 part_valid_reg;

    logic                 accept;
    logic                 col_odd;
    logic                 row_odd;
    logic                 last_col;
    logic                 last_row;
    logic [BLK_W-1:0]     bc;
    logic [BLK_W-1:0]     br;
    logic [PAIR_W-1:0]    pair;
    logic                 opens_pair;
    logic                 keeps_row;
    logic                 row_wr;
    logic                 blk_done;
    logic                 row_rd;
    logic [PAIR_W-1:0]    row_rd_data;
    logic [PAIR_W-1:0]    partial;

    assign s_ready  = in_enable && (!s1_valid_reg || !blk_full);
    assign accept   = s_valid && s_ready;

    assign col_odd  = col_reg[0];
    assign row_odd  = row_reg[0];
    assign last_col = (col_reg >= geom.last_col);
    assign last_row = (row_reg >= geom.last_row);
    assign bc       = col_reg[BLK_W:1];
    assign br       = row_reg[BLK_W:1];

    assign pair = (col_odd ? PAIR_W'(pair_acc_reg) : '0) + PAIR_W'(s_coverage);

    // An even column that is not the last only opens a horizontal pair; an even
    // row that is not the last parks its pair sum in the line buffer.
    assign opens_pair = !col_odd && !last_col;
    assign keeps_row  = !row_odd && !last_row;
    assign row_wr     = accept && !opens_pair && keeps_row;
    assign blk_done   = accept && !opens_pair && !keeps_row;
    assign row_rd     = blk_done && row_odd;

    always_comb begin
        col_next = col_reg + POS_W'(1);
        row_next = row_reg;
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + POS_W'(1);
        end
    end

    gbdmb_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (HALF_SIDE)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (row_wr),
        .waddr (bc),
        .wdata (pair),
        .re    (row_rd),
        .raddr (bc),
        .rdata (row_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            pair_acc_reg <= '0;
            seen_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
                if (opens_pair) begin
                    pair_acc_reg <= s_coverage;
                end
            end
            if (row_wr) begin
                seen_reg[bc] <= 1'b1;
            end
            if (blk_done) begin
                s1_valid_reg <= 1'b1;
            end else if (!blk_full) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (blk_done) begin
            s1_pair_reg    <= pair;
            s1_col_odd_reg <= col_odd;
            s1_row_odd_reg <= row_odd;
            s1_bc_reg      <= bc;
            s1_br_reg      <= br;
            s1_last_reg    <= last_col && last_row;
        end
        if (row_rd) begin
            part_valid_reg <= seen_reg[bc];
        end
    end

    // A line buffer entry never written since reset reads as zero.
    assign partial = (s1_row_odd_reg && part_valid_reg) ? row_rd_data : '0;

    assign blk_push         = s1_valid_reg && !blk_full;
    assign blk_data.sum     = SUM_W'(s1_pair_reg) + SUM_W'(partial);
    assign blk_data.col_odd = s1_col_odd_reg;
    assign blk_data.row_odd = s1_row_odd_reg;
    assign blk_data.bc      = s1_bc_reg;
    assign blk_data.br      = s1_br_reg;
    assign blk_data.last    = s1_last_reg;

`ifndef SYNTHESIS
    a_hold_block_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && blk_full |=> s1_valid_reg && $stable(s1_pair_reg))
        else $error("pending block lost while the queue was full");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/gbdmb_back.sv -----
// Pixel back end: averages each block, places and clips it, computes the byte
// offset and max-blends the alpha store. Also runs the store clearing pass.
// Depends on gbdmb_pkg and gbdmb_ram.
`default_nettype none

module gbdmb_back
    import gbdmb_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire back_cfg_t           geom,
    input  wire logic                blk_empty,
    output logic                     blk_pop,
    input  wire blk_t                blk_head,
    output logic                     store_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [OFFSET_W-1:0]      m_byte_offset,
    output logic [COV_W-1:0]         m_alpha,
    output logic                     m_stored,
    output logic                     m_last
);

    logic                clearing_reg;
    logic [STORE_AW-1:0] clear_addr_reg;

    logic                b1_valid_reg;
    logic [COV_W-1:0]    b1_alpha_reg;
    logic [PX_W-1:0]     b1_px_reg;
    logic [PY_W-1:0]     b1_py_reg;
    logic                b1_inside_reg;
    logic                b1_last_reg;

    logic                b2_valid_reg;
    logic [COV_W-1:0]    b2_alpha_reg;
    logic [OFFSET_W-1:0] b2_offset_reg;
    logic [STORE_AW-1:0] b2_addr_reg;
    logic                b2_inside_reg;
    logic                b2_last_reg;

    logic                lw_valid_reg;
    logic [STORE_AW-1:0] lw_addr_reg;
    logic [COV_W-1:0]    lw_alpha_reg;

    logic                m_valid_reg;

    logic                b1_adv;
    logic                b2_adv;
    logic [SUM_W:0]      avg;
    logic [COORD_W-1:0]  px;
    logic [COORD_W-1:0]  py;
    logic                on_surface;
    logic [OFFSET_W-1:0] px3;
    logic [OFFSET_W-1:0] offset;
    logic                store_re;
    logic [COV_W-1:0]    store_rd;
    logic [COV_W-1:0]    old_alpha;
    logic                do_store;
    logic                store_wr;
    logic                ram_we;
    logic [STORE_AW-1:0] ram_waddr;
    logic [COV_W-1:0]    ram_wdata;

    assign b2_adv      = !m_valid_reg || m_ready;
    assign b1_adv      = !b2_valid_reg || b2_adv;
    assign blk_pop     = !blk_empty && (!b1_valid_reg || b1_adv);
    assign store_ready = !clearing_reg;

    // Rounded average over the 1, 2 or 4 samples of the block.
    always_comb begin
        case ({blk_head.col_odd, blk_head.row_odd}) inside
            2'b11:        avg = ((SUM_W + 1)'(blk_head.sum) + (SUM_W + 1)'(2)) >> 2;
            2'b10, 2'b01: avg = ((SUM_W + 1)'(blk_head.sum) + (SUM_W + 1)'(1)) >> 1;
            default:      avg = (SUM_W + 1)'(blk_head.sum);
        endcase
    end

    assign px = {{(COORD_W - DEST_W){geom.dest_x[DEST_W-1]}}, geom.dest_x}
              + COORD_W'(blk_head.bc);
    assign py = {{(COORD_W - DEST_W){geom.dest_y[DEST_W-1]}}, geom.dest_y}
              + COORD_W'(blk_head.br);

    assign on_surface = !px[COORD_W-1] && !py[COORD_W-1]
                     && (px[COORD_W-2:0] < (COORD_W - 1)'(geom.surf_w))
                     && (py[COORD_W-2:0] < (COORD_W - 1)'(geom.surf_h));

    assign px3    = (OFFSET_W'(b1_px_reg) << 1) + OFFSET_W'(b1_px_reg);
    assign offset = b1_inside_reg
                  ? OFFSET_W'(b1_py_reg) * OFFSET_W'(geom.stride) + px3
                  : '0;

    assign store_re = b1_valid_reg && b1_adv;

    // The pixel ahead writes on the same edge that this pixel reads, so the
    // most recent write to the same address overrides the read data.
    assign old_alpha = (lw_valid_reg && (lw_addr_reg == b2_addr_reg)) ? lw_alpha_reg
                                                                      : store_rd;
    assign do_store  = b2_inside_reg && (b2_alpha_reg != '0) && (b2_alpha_reg > old_alpha);
    assign store_wr  = b2_valid_reg && b2_adv && do_store;

    assign ram_we    = clearing_reg || store_wr;
    assign ram_waddr = clearing_reg ? clear_addr_reg : b2_addr_reg;
    assign ram_wdata = clearing_reg ? '0 : b2_alpha_reg;

    gbdmb_ram #(
        .WIDTH (COV_W),
        .DEPTH (STORE_DEPTH)
    ) u_alpha_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (store_re),
        .raddr ({b1_py_reg, b1_px_reg}),
        .rdata (store_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
            b1_valid_reg   <= 1'b0;
            b2_valid_reg   <= 1'b0;
            lw_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (clearing_reg) begin
                clear_addr_reg <= clear_addr_reg + STORE_AW'(1);
                if (clear_addr_reg == STORE_AW'(STORE_DEPTH - 1)) begin
                    clearing_reg <= 1'b0;
                end
            end
            if (blk_pop) begin
                b1_valid_reg <= 1'b1;
            end else if (b1_adv) begin
                b1_valid_reg <= 1'b0;
            end
            if (b1_adv) begin
                b2_valid_reg <= b1_valid_reg;
            end
            if (b2_adv) begin
                m_valid_reg <= b2_valid_reg;
            end
            if (store_wr) begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (blk_pop) begin
            b1_alpha_reg  <= avg[COV_W-1:0];
            b1_px_reg     <= px[PX_W-1:0];
            b1_py_reg     <= py[PY_W-1:0];
            b1_inside_reg <= on_surface;
            b1_last_reg   <= blk_head.last;
        end
        if (store_re) begin
            b2_alpha_reg  <= b1_alpha_reg;
            b2_offset_reg <= offset;
            b2_addr_reg   <= {b1_py_reg, b1_px_reg};
            b2_inside_reg <= b1_inside_reg;
            b2_last_reg   <= b1_last_reg;
        end
        if (store_wr) begin
            lw_addr_reg  <= b2_addr_reg;
            lw_alpha_reg <= b2_alpha_reg;
        end
        if (b2_valid_reg && b2_adv) begin
            m_byte_offset <= b2_offset_reg;
            m_alpha       <= b2_alpha_reg;
            m_stored      <= do_store;
            m_last        <= b2_last_reg;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_stored_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stored |-> m_alpha != '0)
        else $error("pixel reported stored with zero alpha");
    a_idle_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !b1_valid_reg && !b2_valid_reg && !m_valid_reg)
        else $error("pixel in flight during the store clearing pass");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/glyph_box_downsample_max_blend.sv -----
// Top level of the 2x2 glyph coverage downsampler with max-blend alpha store.
// A result reaches the m_ channel through the front-end block register, the
// block queue and the back-end b1, b2 and output registers; throughput is one
// sample per cycle, paced by the store read-modify-write pipeline, unless
// m_ready or a full queue stalls it. Reset (synchronous, active low) restores
// the register defaults and clears the 262144-entry alpha store with s_ready low.
`default_nettype none

module glyph_box_downsample_max_blend
    import gbdmb_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [COV_W-1:0]       s_coverage,

    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [OFFSET_W-1:0]         m_byte_offset,
    output logic [COV_W-1:0]            m_alpha,
    output logic                        m_stored,
    output logic                        m_last
);

    logic [GSIZE_W-1:0] glyph_width_reg;
    logic [GSIZE_W-1:0] glyph_height_reg;
    logic [DEST_W-1:0]  dest_x_reg;
    logic [DEST_W-1:0]  dest_y_reg;
    logic [SSIZE_W-1:0] surface_width_reg;
    logic [SSIZE_W-1:0] surface_height_reg;

    front_cfg_t         front_cfg;
    back_cfg_t          back_cfg;
    logic               store_ready;
    logic               blk_push;
    blk_t               blk_in;
    logic               blk_full;
    logic               blk_pop;
    blk_t               blk_head;
    logic               blk_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glyph_width_reg    <= GSIZE_W'(1);
            glyph_height_reg   <= GSIZE_W'(1);
            dest_x_reg         <= '0;
            dest_y_reg         <= '0;
            surface_width_reg  <= SSIZE_W'(MAX_SURFACE_WIDTH);
            surface_height_reg <= SSIZE_W'(MAX_SURFACE_HEIGHT);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GLYPH_WIDTH:    glyph_width_reg    <= cfg_data[GSIZE_W-1:0];
                REG_GLYPH_HEIGHT:   glyph_height_reg   <= cfg_data[GSIZE_W-1:0];
                REG_DEST_X:         dest_x_reg         <= cfg_data[DEST_W-1:0];
                REG_DEST_Y:         dest_y_reg         <= cfg_data[DEST_W-1:0];
                REG_SURFACE_WIDTH:  surface_width_reg  <= cfg_data[SSIZE_W-1:0];
                REG_SURFACE_HEIGHT: surface_height_reg <= cfg_data[SSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign front_cfg.last_col = side_last(glyph_width_reg);
    assign front_cfg.last_row = side_last(glyph_height_reg);

    assign back_cfg.dest_x = dest_x_reg;
    assign back_cfg.dest_y = dest_y_reg;
    assign back_cfg.surf_w = surf_clamp(surface_width_reg, SSIZE_W'(MAX_SURFACE_WIDTH));
    assign back_cfg.surf_h = surf_clamp(surface_height_reg, SSIZE_W'(MAX_SURFACE_HEIGHT));
    assign back_cfg.stride = row_stride(back_cfg.surf_w);

    gbdmb_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_enable  (store_ready),
        .geom       (front_cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_coverage (s_coverage),
        .blk_push   (blk_push),
        .blk_data   (blk_in),
        .blk_full   (blk_full)
    );

    gbdmb_fifo u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (blk_push),
        .push_data (blk_in),
        .full      (blk_full),
        .pop       (blk_pop),
        .pop_data  (blk_head),
        .empty     (blk_empty)
    );

    gbdmb_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .geom          (back_cfg),
        .blk_empty     (blk_empty),
        .blk_pop       (blk_pop),
        .blk_head      (blk_head),
        .store_ready   (store_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_byte_offset (m_byte_offset),
        .m_alpha       (m_alpha),
        .m_stored      (m_stored),
        .m_last        (m_last)
    );

`ifndef SYNTHESIS
    a_no_input_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        !store_ready |-> !s_ready)
        else $error("sample accepted before the alpha store was cleared");
`endif

endmodule

`default_nettype wire

// ----- bench/glyph_pixel_checker.sv -----
// Checker for the glyph box downsampler: it follows the configuration, input and
// result transactions, predicts every output pixel and compares it field by field.
// Depends on gbdmb_pkg for widths, sizing and register indexes.

module glyph_pixel_checker
    import gbdmb_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   s_valid,
    input  wire logic                   s_ready,
    input  wire logic [COV_W-1:0]       s_coverage,
    input  wire logic                   m_valid,
    input  wire logic                   m_ready,
    input  wire logic [OFFSET_W-1:0]    m_byte_offset,
    input  wire logic [COV_W-1:0]       m_alpha,
    input  wire logic                   m_stored,
    input  wire logic                   m_last,
    output int                          failures,
    output int                          pending,
    output int                          samples_seen,
    output int                          pixels_checked,
    output int                          stores_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [OFFSET_W-1:0] byte_offset;
        logic [COV_W-1:0]    alpha;
        logic                stored;
        logic                last;
    } pixel_result_t;

    pixel_result_t expected_pixels[$];

    // Register copies as the block holds them, before any clamping.
    logic [GSIZE_W-1:0]       glyph_w;
    logic [GSIZE_W-1:0]       glyph_h;
    logic signed [DEST_W-1:0] org_x;
    logic signed [DEST_W-1:0] org_y;
    logic [SSIZE_W-1:0]       surf_w;
    logic [SSIZE_W-1:0]       surf_h;

    int       col_pos;
    int       row_pos;
    int       first_of_pair;
    int       pair_sums [HALF_SIDE];
    bit [7:0] surface_alpha [STORE_DEPTH];

    function automatic int fit_size(input int v, input int hi);
        if (v < 1) begin
            return 1;
        end else if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endtask

    task automatic predict_coverage_sample(input logic [COV_W-1:0] cov);
        int gw;
        int gh;
        int sw;
        int sh;
        int bc;
        int br;
        int px;
        int py;
        int pair;
        int sum;
        int count;
        int stride;
        bit col_odd;
        bit row_odd;
        bit last_col;
        bit last_row;
        pixel_result_t px_out;
        gw = fit_size(int'(glyph_w), MAX_GLYPH_SIDE);
        gh = fit_size(int'(glyph_h), MAX_GLYPH_SIDE);
        sw = fit_size(int'(surf_w), MAX_SURFACE_WIDTH);
        sh = fit_size(int'(surf_h), MAX_SURFACE_HEIGHT);
        col_odd = (col_pos % 2) != 0;
        row_odd = (row_pos % 2) != 0;
        // After a size change mid-glyph the position may lie past the new edge.
        last_col = col_pos >= gw - 1;
        last_row = row_pos >= gh - 1;
        bc = (col_pos / OVERSAMPLE) % HALF_SIDE;
        br = row_pos / OVERSAMPLE;

        if (!col_odd && !last_col) begin
            first_of_pair = int'(cov);
        end else begin
            pair = (col_odd ? first_of_pair : 0) + int'(cov);
            if (!row_odd && !last_row) begin
                pair_sums[bc] = pair;
            end else begin
                sum = pair + (row_odd ? pair_sums[bc] : 0);
                count = (col_odd ? 2 : 1) * (row_odd ? 2 : 1);
                px_out.alpha = COV_W'((sum + count / 2) / count);
                px_out.byte_offset = '0;
                px_out.stored = 1'b0;
                px_out.last = last_col && last_row;
                px = int'(org_x) + bc;
                py = int'(org_y) + br;
                if (px >= 0 && py >= 0 && px < sw && py < sh) begin
                    stride = (sw * 3 + 3) & ~3;
                    px_out.byte_offset = OFFSET_W'(py * stride + px * 3);
                    if (px_out.alpha != 0 &&
                        px_out.alpha > surface_alpha[py * MAX_SURFACE_WIDTH + px]) begin
                        surface_alpha[py * MAX_SURFACE_WIDTH + px] = px_out.alpha;
                        px_out.stored = 1'b1;
                    end
                end
                expected_pixels.push_back(px_out);
            end
        end

        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    always @(posedge aclk) begin
        pixel_result_t want;
        if (!aresetn) begin
            glyph_w = GSIZE_W'(1);
            glyph_h = GSIZE_W'(1);
            org_x = '0;
            org_y = '0;
            surf_w = SSIZE_W'(MAX_SURFACE_WIDTH);
            surf_h = SSIZE_W'(MAX_SURFACE_HEIGHT);
            col_pos = 0;
            row_pos = 0;
            first_of_pair = 0;
            foreach (pair_sums[i]) pair_sums[i] = 0;
            foreach (surface_alpha[i]) surface_alpha[i] = '0;
            expected_pixels.delete();
            failures = 0;
            samples_seen = 0;
            pixels_checked = 0;
            stores_seen = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_GLYPH_WIDTH:    glyph_w = cfg_data[GSIZE_W-1:0];
                    REG_GLYPH_HEIGHT:   glyph_h = cfg_data[GSIZE_W-1:0];
                    REG_DEST_X:         org_x = cfg_data;
                    REG_DEST_Y:         org_y = cfg_data;
                    REG_SURFACE_WIDTH:  surf_w = cfg_data[SSIZE_W-1:0];
                    REG_SURFACE_HEIGHT: surf_h = cfg_data[SSIZE_W-1:0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                predict_coverage_sample(s_coverage);
                samples_seen++;
            end

            if (m_valid === 1'b1 && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("pixel transaction with no expected pixel: offset %0d, alpha %0d",
                           m_byte_offset, m_alpha);
                    failures++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("byte_offset", 32'(want.byte_offset), 32'(m_byte_offset));
                    check_field("alpha", 32'(want.alpha), 32'(m_alpha));
                    check_field("stored", 32'(want.stored), 32'(m_stored));
                    check_field("last", 32'(want.last), 32'(m_last));
                    pixels_checked++;
                    if (want.stored) begin
                        stores_seen++;
                    end
                end
            end
        end
        pending = expected_pixels.size();
    end

endmodule

// ----- bench/testbench.sv -----
// Top of the glyph box downsampler bench: clock, reset, configuration and sample
// stimulus, result back-pressure and the verdict. Needs the block's RTL,
// gbdmb_pkg and glyph_pixel_checker.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import gbdmb_pkg::*;

    localparam int RANDOM_ITEMS  = 2000;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;

    // Index beyond the register file; the block must ignore writes to it.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

    localparam logic [7:0] CORNER_SAMPLES [4] = '{8'd128, 8'd255, 8'd0, 8'd200};
    localparam logic [7:0] EDGE_SAMPLES [9] =
        '{8'd255, 8'd254, 8'd1, 8'd255, 8'd255, 8'd7, 8'd0, 8'd128, 8'd255};
    localparam logic [7:0] SHRINK_HEAD [5] = '{8'd10, 8'd20, 8'd30, 8'd40, 8'd50};
    localparam logic [7:0] SHRINK_TAIL [3] = '{8'd255, 8'd3, 8'd254};

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    logic [COV_W-1:0]       s_coverage;
    logic                   m_valid;
    logic                   m_ready;
    logic [OFFSET_W-1:0]    m_byte_offset;
    logic [COV_W-1:0]       m_alpha;
    logic                   m_stored;
    logic                   m_last;

    int failures;
    int pending;
    int samples_seen;
    int pixels_checked;
    int stores_seen;
    int send_idle_pct;
    int recv_idle_pct;
    int cycle_count;
    int settings_used;
    bit stall_request;

    glyph_box_downsample_max_blend uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_coverage    (s_coverage),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_byte_offset (m_byte_offset),
        .m_alpha       (m_alpha),
        .m_stored      (m_stored),
        .m_last        (m_last)
    );

    glyph_pixel_checker pixel_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_coverage     (s_coverage),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_byte_offset  (m_byte_offset),
        .m_alpha        (m_alpha),
        .m_stored       (m_stored),
        .m_last         (m_last),
        .failures       (failures),
        .pending        (pending),
        .samples_seen   (samples_seen),
        .pixels_checked (pixels_checked),
        .stores_seen    (stores_seen)
    );

    initial begin
        aclk = 1'b0;
    end

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        cycle_count = 0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request so
    // the block's internal queue fills and it has to refuse samples.
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (stall_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Leaves cfg_valid high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_geometry(input logic [8:0] gw, input logic [8:0] gh,
                                input logic [10:0] dx, input logic [10:0] dy,
                                input logic [9:0] sw, input logic [9:0] sh);
        write_reg(REG_GLYPH_WIDTH, CFG_DATA_W'(gw));
        write_reg(REG_GLYPH_HEIGHT, CFG_DATA_W'(gh));
        write_reg(REG_DEST_X, dx);
        write_reg(REG_DEST_Y, dy);
        write_reg(REG_SURFACE_WIDTH, CFG_DATA_W'(sw));
        write_reg(REG_SURFACE_HEIGHT, CFG_DATA_W'(sh));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic push_coverage(input logic [COV_W-1:0] cov);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_coverage <= cov;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Waits until every predicted pixel has come out, then lets the pipeline
    // settle so that no sample without a result is still in flight.
    task automatic drain_pixels();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        int         random_sent;
        int         sample_count;
        int         full_area;
        int         shape;
        bit         pressure_done;
        logic [8:0]  gw;
        logic [8:0]  gh;
        logic [10:0] dx;
        logic [10:0] dy;
        logic [9:0]  sw;
        logic [9:0]  sh;
        logic [7:0]  cov;

        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_coverage = '0;
        stall_request = 1'b0;
        settings_used = 0;
        send_idle_pct = 29;
        recv_idle_pct = 88;
        random_sent = 0;
        pressure_done = 1'b0;

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Single-sample glyphs (zero sizes count as one) on the far corner of a
        // saturated surface: max offset, max blend, zero alpha not stored.
        set_geometry(9'd0, 9'd0, 11'd511, 11'd511, 10'd1023, 10'd1023);
        foreach (CORNER_SAMPLES[i]) push_coverage(CORNER_SAMPLES[i]);
        drain_pixels();

        // 3x3 glyph: partial blocks at the right and bottom edges, one pixel
        // left of a one-pixel surface and one below it.
        write_reg(REG_SPARE, 11'h7FF);
        set_geometry(9'd3, 9'd3, 11'h7FF, 11'd0, 10'd0, 10'd0);
        foreach (EDGE_SAMPLES[i]) push_coverage(EDGE_SAMPLES[i]);
        drain_pixels();

        // Stop inside a 4x2 glyph, then shrink it to one column: the stale
        // partial sum of the first row is used as it stands.
        set_geometry(9'd4, 9'd2, 11'h400, 11'd1023, 10'd1, 10'd1);
        foreach (SHRINK_HEAD[i]) push_coverage(SHRINK_HEAD[i]);
        drain_pixels();
        set_geometry(9'd1, 9'd2, 11'd0, 11'd0, 10'd1, 10'd1);
        foreach (SHRINK_TAIL[i]) push_coverage(SHRINK_TAIL[i]);
        drain_pixels();

        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent < RANDOM_ITEMS / 3) begin
                send_idle_pct = 29;
                recv_idle_pct = 88;
            end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 88;
                recv_idle_pct = 29;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (send_idle_pct == 0 && !pressure_done) begin
                pressure_done = 1'b1;
                set_geometry(9'd32, 9'd16, 11'd0, 11'd0, 10'd100, 10'd100);
                sample_count = 512;
                stall_request = 1'b1;
            end else begin
                shape = $urandom_range(0, 9);
                if (shape == 0) begin
                    gw = 9'($urandom_range(256, 511));
                    gh = 9'($urandom_range(0, 2));
                end else if (shape == 1) begin
                    gw = 9'($urandom_range(0, 2));
                    gh = 9'($urandom_range(256, 511));
                end else begin
                    gw = 9'($urandom_range(0, 20));
                    gh = 9'($urandom_range(0, 20));
                end
                // Half the placements land near the origin so pixels overlap
                // and the max blend gets exercised.
                dx = $urandom_range(0, 1) ? 11'($urandom_range(0, 2047))
                                          : 11'(int'($urandom_range(0, 40)) - 8);
                dy = $urandom_range(0, 1) ? 11'($urandom_range(0, 2047))
                                          : 11'(int'($urandom_range(0, 40)) - 8);
                sw = $urandom_range(0, 1) ? 10'($urandom_range(0, 1023))
                                          : 10'($urandom_range(1, 40));
                sh = $urandom_range(0, 1) ? 10'($urandom_range(0, 1023))
                                          : 10'($urandom_range(1, 40));
                set_geometry(gw, gh, dx, dy, sw, sh);
                full_area = (gw == 0 ? 1 : (gw > 256 ? 256 : int'(gw))) *
                            (gh == 0 ? 1 : (gh > 256 ? 256 : int'(gh)));
                // Now and then the phase stops inside a glyph.
                sample_count = ($urandom_range(0, 5) == 0) ? $urandom_range(1, full_area)
                                                           : full_area;
            end

            repeat (sample_count) begin
                case ($urandom_range(0, 7))
                    0:       cov = 8'd0;
                    1:       cov = 8'd255;
                    default: cov = 8'($urandom_range(0, 255));
                endcase
                push_coverage(cov);
                random_sent++;
            end
            drain_pixels();
        end

        repeat (2 * SETTLE_CYCLES) @(negedge aclk);

        $display("Sent %0d coverage samples under %0d register settings.",
                 samples_seen, settings_used);
        $display("Compared %0d output pixels, %0d of them written to the alpha surface.",
                 pixels_checked, stores_seen);
        if (failures == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
